// ===== hw/rtl/ssdh_pkg.sv =====
// shared constants, types and state codes of the stream seed derivation hash
`timescale 1ns / 1ps
`default_nettype none
package ssdh_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = WordW / 2;
  localparam int unsigned ByteW = 8;

  // fnv-1a parameters
  localparam logic [WordW-1:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;
  localparam logic [WordW-1:0] FnvPrime = 64'h0000_0100_0000_01b3;

  // splitmix64 finalizer constants
  localparam logic [WordW-1:0] MixGolden = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WordW-1:0] MixMulA   = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WordW-1:0] MixMulB   = 64'h94d0_49bb_1331_11eb;
  localparam int unsigned MixShift1 = 30;
  localparam int unsigned MixShift2 = 27;
  localparam int unsigned MixShift3 = 31;

  // multiplier partial-product steps
  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mul_step_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH_MUL,
    ST_MIX_ADD,
    ST_MUL_A,
    ST_MUL_B,
    ST_FIN
  } seq_state_e;

  // request to the shared multiplier
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } mul_req_t;

  // response of the shared multiplier
  typedef struct packed {
    logic             done;
    logic [WordW-1:0] p;
  } mul_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ssdh_mul.sv =====
// iterative 64x64 multiplier modulo 2^64 built on one 32x32 product per cycle
`timescale 1ns / 1ps
`default_nettype none
module ssdh_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssdh_pkg::mul_req_t req_i,
  output ssdh_pkg::mul_rsp_t rsp_o
);
  import ssdh_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  mul_step_e        step_q, step_d;
  logic [WordW-1:0] a_q, a_d;
  logic [WordW-1:0] b_q, b_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [HalfW-1:0] op_x, op_y;
  logic [WordW-1:0] prod;

  // operand selection for the shared 32x32 multiplier
  always_comb begin
    unique case (step_q)
      MUL_LL: begin
        op_x = a_q[HalfW-1:0];
        op_y = b_q[HalfW-1:0];
      end
      MUL_LH: begin
        op_x = a_q[HalfW-1:0];
        op_y = b_q[WordW-1:HalfW];
      end
      MUL_HL: begin
        op_x = a_q[WordW-1:HalfW];
        op_y = b_q[HalfW-1:0];
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  assign prod = WordW'(op_x) * WordW'(op_y);

  // step sequencing and accumulation
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (busy_q) begin
      unique case (step_q)
        MUL_LL: begin
          acc_d  = prod;
          step_d = MUL_LH;
        end
        MUL_LH: begin
          acc_d  = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
          step_d = MUL_HL;
        end
        MUL_HL: begin
          acc_d  = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
          step_d = MUL_LL;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: begin
          step_d = MUL_LL;
          busy_d = 1'b0;
        end
      endcase
    end else if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = req_i.b;
      step_d = MUL_LL;
      busy_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= MUL_LL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule
`default_nettype wire

// ===== hw/rtl/stream_seed_derivation_hash_top.sv =====
// top level: fnv-1a label hash with splitmix64 finalizer on a shared multiplier
// a byte word goes through 3 product steps of the shared 32x32 multiplier plus start and finish
// before the next word is accepted; a word with no byte, not last, leaves the input ready
// on a last word the result is valid after the finalizer, preceded by the byte hash if the word has one
// (the two finalizer multiplies each run through the same multiplier)
// reset is asynchronous active low: accumulator to the fnv offset basis, run seed to 0
`timescale 1ns / 1ps
`default_nettype none
module stream_seed_derivation_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel: run seed
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_wdata_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] label_byte
  input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // last
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [63:0] stream_seed
);
  import ssdh_pkg::*;

  seq_state_e       state_q, state_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [WordW-1:0] seed_q;
  logic [WordW-1:0] work_q, work_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_data_q, out_data_d;
  logic [WordW-1:0] mix_sum;
  logic [WordW-1:0] fold;
  logic             in_acc;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign mix_sum       = work_q + MixGolden;
  assign fold          = acc_q ^ WordW'(s_axis_tdata);

  // shared multiplier
  ssdh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    work_d      = work_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mul_req     = '{start: 1'b0, a: '0, b: '0};
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          last_d = s_axis_tlast;
          if (s_axis_tuser[0]) begin
            mul_req = '{start: 1'b1, a: fold, b: FnvPrime};
            state_d = ST_HASH_MUL;
          end else if (s_axis_tlast) begin
            work_d  = acc_q ^ seed_q;
            acc_d   = FnvBasis;
            state_d = ST_MIX_ADD;
          end
        end
      end
      ST_HASH_MUL: begin
        if (mul_rsp.done) begin
          if (last_q) begin
            work_d  = mul_rsp.p ^ seed_q;
            acc_d   = FnvBasis;
            state_d = ST_MIX_ADD;
          end else begin
            acc_d   = mul_rsp.p;
            state_d = ST_IDLE;
          end
        end
      end
      ST_MIX_ADD: begin
        mul_req = '{start: 1'b1, a: mix_sum ^ (mix_sum >> MixShift1), b: MixMulA};
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        if (mul_rsp.done) begin
          mul_req = '{start: 1'b1, a: mul_rsp.p ^ (mul_rsp.p >> MixShift2), b: MixMulB};
          state_d = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (mul_rsp.done) begin
          work_d  = mul_rsp.p;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = work_q ^ (work_q >> MixShift3);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= FnvBasis;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // working and output word registers
  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ssdh_checker.sv =====
// port-level checks of the stream seed derivation hash, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ssdh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a hashed byte or a label end keeps the block busy in the next cycle
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser[0] || s_axis_tlast) |=> !s_axis_tready)
    else $error("input ready right after a word that needs work");

  // a new result only appears after a busy stretch
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without preceding work");

  // a label end cannot produce its result in the next cycle
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("result too early after label end");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not taken");

endmodule

bind stream_seed_derivation_hash_top ssdh_checker u_ssdh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
